>>> src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Types and constants shared by the block request splitter modules.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned CNT_W      = 30;
  localparam int unsigned LBA_W      = 32;
  localparam int unsigned BSIZE_W    = 13;
  localparam int unsigned NBLK_W     = 16;
  localparam int unsigned LEN_W      = 28;
  localparam int unsigned TMO_W      = 27;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [BSIZE_W-1:0] BSIZE_MAX = 13'd4096;

  localparam int unsigned MAX_BLOCKS_PER_COMMAND = 65535;
  localparam int unsigned MAX_RUNS               = 33;
  localparam int unsigned MAX_TOTAL_BLOCKS       = MAX_BLOCKS_PER_COMMAND * MAX_RUNS;
  localparam int unsigned JOB_BLK_W              = $clog2(MAX_TOTAL_BLOCKS + 1);

  localparam int unsigned DIV_CNT_W = $clog2(CNT_W);

  localparam int unsigned TMO_SHIFT = 21;
  localparam logic [19:0] TMO_US    = 20'd1000000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MEDIA = 3'd1;
  localparam logic [2:0] ST_WP    = 3'd2;
  localparam logic [2:0] ST_INVAL = 3'd3;
  localparam logic [2:0] ST_SIZE  = 3'd4;

  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;

  localparam logic [CFG_IDX_W-1:0] REG_MEDIA_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_BLOCK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IO_ALIGN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR     = 3'd5;

  typedef struct packed {
    logic              is_read;
    logic [31:0]       req_media_id;
    logic [LBA_W-1:0]  start_lba;
    logic [CNT_W-1:0]  byte_count;
    logic [63:0]       buffer_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              command_valid;
    logic [5:0]        command_index;
    logic [31:0]       command_argument;
    logic [NBLK_W-1:0] block_count;
    logic [LEN_W-1:0]  byte_length;
    logic [TMO_W-1:0]  timeout_us;
    logic [CNT_W-1:0]  buffer_offset;
    logic              is_last;
  } rsp_t;

  typedef struct packed {
    logic [31:0]        media_id;
    logic               read_only;
    logic [BSIZE_W-1:0] block_size;
    logic [31:0]        last_block;
    logic [BSIZE_W-1:0] io_align;
    logic               sector_addressing;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 plain;
    logic                 is_read;
    logic [LBA_W-1:0]     lba;
    logic [JOB_BLK_W-1:0] blocks;
  } job_t;

endpackage

>>> src/brs_queue.sv
// ----------------------------------------------------------------------------
// brs_queue
// Short job queue between the request checker and the command generator.
// ----------------------------------------------------------------------------
module brs_queue import brs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;

  assign full_o     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/brs_front.sv
// ----------------------------------------------------------------------------
// brs_front
// Accepts a request, runs the parameter checks and the bit-serial divide of
// the byte count by the block size, and queues one job per request.
// ----------------------------------------------------------------------------
module brs_front import brs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic push_o,
  output job_t push_data_o,
  input  logic full_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_CHK  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e              state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]     dq_q, dq_d;
  logic [BSIZE_W-2:0]   rem_q, rem_d;
  logic [LBA_W-1:0]     lba_q, lba_d;
  logic [BSIZE_W-1:0]   buf_lo_q, buf_lo_d;
  logic                 rd_q, rd_d;
  logic [2:0]           st_q, st_d;
  logic                 plain_q, plain_d;

  logic                 accept;
  logic                 early;
  logic [2:0]           early_st;
  logic [BSIZE_W-1:0]   rem_sh;
  logic                 ge;
  logic [LBA_W+1:0]     last_lba;
  logic                 range_bad;
  logic                 align_bad;
  logic                 runs_bad;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  always_comb begin
    early    = 1'b1;
    early_st = ST_OK;
    if (in_data_i.req_media_id != cfg_i.media_id) begin
      early_st = ST_MEDIA;
    end else if (!in_data_i.is_read && cfg_i.read_only) begin
      early_st = ST_WP;
    end else if (in_data_i.buffer_address == '0) begin
      early_st = ST_INVAL;
    end else if (in_data_i.byte_count == '0) begin
      early_st = ST_OK;
    end else if (cfg_i.block_size == '0 || cfg_i.block_size > BSIZE_MAX) begin
      early_st = ST_SIZE;
    end else begin
      early = 1'b0;
    end
  end

  // one quotient bit per cycle
  assign rem_sh = {rem_q, dq_q[CNT_W-1]};
  assign ge     = (rem_sh >= cfg_i.block_size);

  assign last_lba  = {2'b00, lba_q} + (LBA_W+2)'(dq_q) - (LBA_W+2)'(1);
  assign range_bad = (last_lba > {2'b00, cfg_i.last_block});
  assign align_bad = (cfg_i.io_align != '0) &&
                     ((buf_lo_q & (cfg_i.io_align - BSIZE_W'(1))) != '0);
  assign runs_bad  = (dq_q > CNT_W'(MAX_TOTAL_BLOCKS));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    lba_d    = lba_q;
    buf_lo_d = buf_lo_q;
    rd_d     = rd_q;
    st_d     = st_q;
    plain_d  = plain_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          lba_d    = in_data_i.start_lba;
          buf_lo_d = in_data_i.buffer_address[BSIZE_W-1:0];
          rd_d     = in_data_i.is_read;
          dq_d     = in_data_i.byte_count;
          rem_d    = '0;
          cnt_d    = DIV_CNT_W'(CNT_W - 1);
          st_d     = early_st;
          plain_d  = early;
          state_d  = early ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        rem_d = ge ? (BSIZE_W-1)'(rem_sh - cfg_i.block_size) : rem_sh[BSIZE_W-2:0];
        dq_d  = {dq_q[CNT_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = F_CHK;
        end
      end
      F_CHK: begin
        plain_d = 1'b1;
        if (rem_q != '0) begin
          st_d = ST_SIZE;
        end else if (range_bad || align_bad || runs_bad) begin
          st_d = ST_INVAL;
        end else begin
          st_d    = ST_OK;
          plain_d = 1'b0;
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign push_o              = (state_q == F_PUSH) && !full_i;
  assign push_data_o.status  = st_q;
  assign push_data_o.plain   = plain_q;
  assign push_data_o.is_read = rd_q;
  assign push_data_o.lba     = lba_q;
  assign push_data_o.blocks  = dq_q[JOB_BLK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    lba_q    <= lba_d;
    buf_lo_q <= buf_lo_d;
    rd_q     <= rd_d;
    st_q     <= st_d;
    plain_q  <= plain_d;
  end

endmodule

>>> src/brs_back.sv
// ----------------------------------------------------------------------------
// brs_back
// Takes jobs from the queue and emits one result per run of blocks, or a
// single status result, through an output register.
// ----------------------------------------------------------------------------
module brs_back import brs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  output logic pop_o,
  input  job_t pop_data_i,
  input  logic empty_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_TMO  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_e;

  bstate_e              state_q, state_d;
  job_t                 job_q;
  logic [JOB_BLK_W-1:0] rem_q;
  logic [LBA_W-1:0]     lba_q;
  logic [CNT_W-1:0]     off_q;
  logic [NBLK_W-1:0]    n_q;
  logic [LEN_W-1:0]     len_q;
  logic [31:0]          arg_q;
  logic [TMO_W-1:0]     tmo_q;
  logic                 out_valid_q;
  rsp_t                 out_q;

  logic [NBLK_W-1:0]    n_next;
  logic [7:0]           tmo_mult;
  logic                 out_free;
  logic                 last_run;
  rsp_t                 rsp;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign n_next   = (rem_q > JOB_BLK_W'(MAX_BLOCKS_PER_COMMAND)) ?
                    NBLK_W'(MAX_BLOCKS_PER_COMMAND) : rem_q[NBLK_W-1:0];
  assign tmo_mult = {1'b0, len_q[LEN_W-1:TMO_SHIFT]} + 8'd1;
  assign last_run = (rem_q == JOB_BLK_W'(n_q));

  always_comb begin
    rsp = '0;
    rsp.status  = job_q.status;
    rsp.is_last = 1'b1;
    if (!job_q.plain) begin
      rsp.command_valid    = 1'b1;
      if (job_q.is_read) begin
        rsp.command_index = (n_q == NBLK_W'(1)) ? CMD_READ_SINGLE : CMD_READ_MULTI;
      end else begin
        rsp.command_index = (n_q == NBLK_W'(1)) ? CMD_WRITE_SINGLE : CMD_WRITE_MULTI;
      end
      rsp.command_argument = arg_q;
      rsp.block_count      = n_q;
      rsp.byte_length      = len_q;
      rsp.timeout_us       = tmo_q;
      rsp.buffer_offset    = off_q;
      rsp.is_last          = last_run;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = pop_data_i.plain ? B_EMIT : B_MUL;
        end
      end
      B_MUL:  state_d = B_TMO;
      B_TMO:  state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          state_d = (job_q.plain || last_run) ? B_IDLE : B_MUL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          job_q <= pop_data_i;
          rem_q <= pop_data_i.blocks;
          lba_q <= pop_data_i.lba;
          off_q <= '0;
        end
      end
      B_MUL: begin
        n_q   <= n_next;
        len_q <= LEN_W'(n_next) * LEN_W'(cfg_i.block_size);
        arg_q <= cfg_i.sector_addressing ? lba_q : 32'(lba_q * cfg_i.block_size);
      end
      B_TMO: begin
        tmo_q <= TMO_W'(tmo_mult) * TMO_W'(TMO_US);
      end
      B_EMIT: begin
        if (out_free) begin
          out_q <= rsp;
          rem_q <= rem_q - JOB_BLK_W'(n_q);
          lba_q <= lba_q + LBA_W'(n_q);
          off_q <= off_q + CNT_W'(len_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/block_request_splitter.sv
// ----------------------------------------------------------------------------
// block_request_splitter
// Checks block read/write requests and splits them into SD card commands.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (valid/stall) and results leave on the
// out channel (valid/stall); an item moves when valid is high and stall low.
// Media parameters are set through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i); the user must write them only while no request is in flight,
// which the block does not enforce. A request failing an early check (media,
// write protect, null buffer, zero count, bad block size) goes straight to
// the push state; otherwise the byte count is divided by the block size one
// quotient bit per cycle, then a check state runs range, alignment and run
// checks. The front takes no new request until its job is queued.
// Per run the back multiplies length and argument, then timeout, then loads
// the output register, waiting there while the output is stalled.
// A two-entry job queue separates front and back; the output register lets
// the back finish the next run while a result waits. When the receiver
// stalls, the output holds, the back waits, the queue fills and the front
// waits to push, with its input stalled. Reset empties the queue and loads
// the register defaults (block size 512, sector addressing on, all else 0).
// ----------------------------------------------------------------------------
module block_request_splitter import brs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_data_o
);

  cfg_t cfg_q;
  logic push;
  job_t push_data;
  logic pop;
  job_t pop_data;
  logic full;
  logic empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.media_id          <= '0;
      cfg_q.read_only         <= 1'b0;
      cfg_q.block_size        <= 13'd512;
      cfg_q.last_block        <= '0;
      cfg_q.io_align          <= '0;
      cfg_q.sector_addressing <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MEDIA_ID:   cfg_q.media_id          <= cfg_wdata_i;
        REG_READ_ONLY:  cfg_q.read_only         <= cfg_wdata_i[0];
        REG_BLOCK_SIZE: cfg_q.block_size        <= cfg_wdata_i[BSIZE_W-1:0];
        REG_LAST_BLOCK: cfg_q.last_block        <= cfg_wdata_i;
        REG_IO_ALIGN:   cfg_q.io_align          <= cfg_wdata_i[BSIZE_W-1:0];
        REG_SECTOR:     cfg_q.sector_addressing <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  brs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  brs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  brs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Watches the block request splitter channels and checks every result.
// ----------------------------------------------------------------------------
// Tracks the media registers through the write port, turns each accepted
// request into the list of card commands (or the single status result) it
// must produce, and compares each accepted result field by field against the
// oldest expected one. Reports the error count, the number of results still
// owed and the number of results seen.
// ----------------------------------------------------------------------------
module brs_checker import brs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  req_t                  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  rsp_t                  out_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o
);

  localparam longint unsigned RUN_BLOCKS = MAX_BLOCKS_PER_COMMAND;
  localparam longint unsigned TMO_STEP   = 2 * 1024 * 1024;
  localparam longint unsigned TMO_UNIT   = 1000 * 1000;

  cfg_t media;
  rsp_t owed_cmds[$];
  int   errors;
  int   results;
  int   pending;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign results_o = results;

  function automatic void plan_commands(input req_t r);
    rsp_t              rs;
    logic [2:0]        st;
    bit                plain;
    longint unsigned   lba, blocks, remaining, offset, n, len, arg, runs;
    lba    = 64'(r.start_lba);
    blocks = 0;
    plain  = 1'b1;
    st     = ST_OK;
    if (r.req_media_id != media.media_id) begin
      st = ST_MEDIA;
    end else if (!r.is_read && media.read_only) begin
      st = ST_WP;
    end else if (r.buffer_address == 64'd0) begin
      st = ST_INVAL;
    end else if (r.byte_count == '0) begin
      st = ST_OK;
    end else if (media.block_size == '0 || media.block_size > BSIZE_MAX) begin
      st = ST_SIZE;
    end else if ((r.byte_count % media.block_size) != '0) begin
      st = ST_SIZE;
    end else begin
      blocks = 64'(r.byte_count) / 64'(media.block_size);
      runs   = (blocks + RUN_BLOCKS - 1) / RUN_BLOCKS;
      if (lba + blocks - 1 > 64'(media.last_block)) begin
        st = ST_INVAL;
      end else if (media.io_align != '0 &&
                   (r.buffer_address & (64'(media.io_align) - 64'd1)) != 64'd0) begin
        st = ST_INVAL;
      end else if (runs > MAX_RUNS) begin
        st = ST_INVAL;
      end else begin
        plain = 1'b0;
      end
    end

    if (plain) begin
      rs         = '0;
      rs.status  = st;
      rs.is_last = 1'b1;
      owed_cmds.push_back(rs);
    end else begin
      remaining = blocks;
      offset    = 0;
      while (remaining > 0) begin
        n   = (remaining <= RUN_BLOCKS) ? remaining : RUN_BLOCKS;
        len = n * 64'(media.block_size);
        arg = media.sector_addressing ? lba : lba * 64'(media.block_size);
        rs               = '0;
        rs.status        = ST_OK;
        rs.command_valid = 1'b1;
        if (r.is_read) begin
          rs.command_index = (n == 1) ? CMD_READ_SINGLE : CMD_READ_MULTI;
        end else begin
          rs.command_index = (n == 1) ? CMD_WRITE_SINGLE : CMD_WRITE_MULTI;
        end
        rs.command_argument = 32'(arg);
        rs.block_count      = NBLK_W'(n);
        rs.byte_length      = LEN_W'(len);
        rs.timeout_us       = TMO_W'((len / TMO_STEP + 1) * TMO_UNIT);
        rs.buffer_offset    = CNT_W'(offset);
        rs.is_last          = (remaining == n);
        owed_cmds.push_back(rs);
        lba       += n;
        offset    += len;
        remaining -= n;
      end
    end
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      media <= '{media_id: '0, read_only: 1'b0, block_size: 13'd512,
                 last_block: '0, io_align: '0, sector_addressing: 1'b1};
      owed_cmds.delete();
      errors  = 0;
      results = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MEDIA_ID:   media.media_id          <= cfg_wdata_i;
          REG_READ_ONLY:  media.read_only         <= cfg_wdata_i[0];
          REG_BLOCK_SIZE: media.block_size        <= cfg_wdata_i[BSIZE_W-1:0];
          REG_LAST_BLOCK: media.last_block        <= cfg_wdata_i;
          REG_IO_ALIGN:   media.io_align          <= cfg_wdata_i[BSIZE_W-1:0];
          REG_SECTOR:     media.sector_addressing <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) plan_commands(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (owed_cmds.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_i);
          errors++;
        end else begin
          want = owed_cmds.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("command_valid", want.command_valid, out_data_i.command_valid);
          check_field("command_index", want.command_index, out_data_i.command_index);
          check_field("command_argument", want.command_argument,
                      out_data_i.command_argument);
          check_field("block_count", want.block_count, out_data_i.block_count);
          check_field("byte_length", want.byte_length, out_data_i.byte_length);
          check_field("timeout_us", want.timeout_us, out_data_i.timeout_us);
          check_field("buffer_offset", want.buffer_offset, out_data_i.buffer_offset);
          check_field("is_last", want.is_last, out_data_i.is_last);
        end
      end
    end
    pending = owed_cmds.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the block request splitter.
// ----------------------------------------------------------------------------
// Programs a series of media settings (reset values, extreme ids and ranges,
// block sizes of 1, 512, 4096, zero and out of range, odd alignments, byte
// addressing), sends directed requests for every check and command type,
// then random phases of mostly well-formed requests mixed with noise, with
// random gaps and output back-pressure except in the final phases. The
// checker beside the block predicts and compares; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_top;
  import brs_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 30;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rsp_t                  out_data;

  int   errors;
  int   pending;
  int   results;
  cfg_t shadow;
  bit   idle_en       = 1'b1;
  int   requests_sent = 0;
  int   settings_used = 0;
  int   quiet_cycles  = 0;

  block_request_splitter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  brs_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t mk_req(input bit rd, input logic [31:0] id,
                                  input logic [31:0] lba, input logic [CNT_W-1:0] cnt,
                                  input logic [63:0] buf_addr);
    req_t r;
    r.is_read        = rd;
    r.req_media_id   = id;
    r.start_lba      = lba;
    r.byte_count     = cnt;
    r.buffer_address = buf_addr;
    return r;
  endfunction

  function automatic cfg_t random_media();
    cfg_t c;
    c.media_id  = $urandom;
    c.read_only = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 19))
      0:                c.block_size = '0;
      1, 2:             c.block_size = BSIZE_W'($urandom_range(4097, 8191));
      3, 4, 5, 6, 7, 8: c.block_size = BSIZE_W'($urandom_range(1, 4096));
      default:          c.block_size = BSIZE_W'(32'd1 << $urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3:    c.io_align = '0;
      4, 5, 6, 7, 8: c.io_align = BSIZE_W'(32'd1 << $urandom_range(0, 12));
      default:       c.io_align = BSIZE_W'($urandom_range(1, 8191));
    endcase
    case ($urandom_range(0, 2))
      0:       c.last_block = '1;
      1:       c.last_block = $urandom;
      default: c.last_block = $urandom_range(0, 100000);
    endcase
    c.sector_addressing = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic req_t make_request(input bit well_formed);
    req_t            r;
    longint unsigned bs, blocks, max_blocks, span, lba;
    int              pick;
    r.is_read        = $urandom_range(0, 1);
    r.req_media_id   = $urandom;
    r.start_lba      = $urandom;
    r.byte_count     = CNT_W'($urandom);
    r.buffer_address = {$urandom, $urandom};
    if (!well_formed) begin
      if ($urandom_range(0, 1)) r.req_media_id = shadow.media_id;
      if ($urandom_range(0, 5) == 0) r.buffer_address = '0;
      if ($urandom_range(0, 5) == 0) r.byte_count = '0;
      return r;
    end
    r.req_media_id = shadow.media_id;
    if (shadow.read_only && $urandom_range(0, 3) != 0) r.is_read = 1'b1;
    bs = 64'(shadow.block_size);
    if (bs == 0 || bs > 4096) begin
      r.byte_count = CNT_W'($urandom_range(0, 100000));
      return r;
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) blocks = $urandom_range(1, 8);
    else if (pick < 8) blocks = $urandom_range(1, 70000);
    else if (pick < 9) blocks = $urandom_range(1, 33 * 65535);
    else blocks = $urandom_range(32 * 65535, 33 * 65535 + 3);
    max_blocks = 64'h3FFF_FFFF / bs;
    if (blocks > max_blocks) blocks = max_blocks;
    r.byte_count = CNT_W'(blocks * bs);
    span = 64'(shadow.last_block) + 1;
    if (blocks <= span) begin
      span = span - blocks;
      if ($urandom_range(0, 7) == 0) lba = span;
      else lba = {$urandom, $urandom} % (span + 1);
      r.start_lba = 32'(lba);
    end
    if (shadow.io_align != '0) begin
      r.buffer_address = r.buffer_address & ~(64'(shadow.io_align) - 64'd1);
      if (r.buffer_address == '0) r.buffer_address = 64'h8000_0000_0000_0000;
    end
    if (r.buffer_address == '0) r.buffer_address = 64'h1;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] junk;
    junk      = $urandom;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (width >= 32) ? value : ((junk << width) | value);
    @(posedge clk);
  endtask

  task automatic program_media(input cfg_t c);
    write_reg(REG_MEDIA_ID, c.media_id, 32);
    write_reg(REG_READ_ONLY, 32'(c.read_only), 1);
    write_reg(REG_BLOCK_SIZE, 32'(c.block_size), BSIZE_W);
    write_reg(REG_LAST_BLOCK, c.last_block, 32);
    write_reg(REG_IO_ALIGN, 32'(c.io_align), BSIZE_W);
    write_reg(REG_SECTOR, 32'(c.sector_addressing), 1);
    cfg_we <= 1'b0;
    shadow = c;
    settings_used++;
  endtask

  always begin
    @(posedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    shadow = '{32'd0, 1'b0, 13'd512, 32'd0, 13'd0, 1'b1};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: one block on the media
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd512, 64'h1000));
    send_req(mk_req(1'b0, 32'd0, 32'd0, 30'd512, 64'h1000));
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd1024, 64'h1000));

    wait_idle();
    program_media('{32'hFFFF_FFFF, 1'b0, 13'd512, 32'hFFFF_FFFF, 13'd0, 1'b1});
    send_req(mk_req(1'b1, 32'h7FFF_FFFF, 32'd0, 30'd512, 64'h1000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'd0, 30'd512, 64'h0));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 32'd0, 30'd0, 64'h1000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'd0, 30'd513, 64'h1000));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd512, 64'h1000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd1024, 64'h1000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'd7, 30'd512 * 30'd65535, 64'h2000));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 32'd100, 30'd512 * 30'd65536, 64'h2000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 30'h3FFF_FE00, '1));

    wait_idle();
    program_media('{32'h5A5A_1234, 1'b1, 13'd1, 32'hFFFF_FFFF, 13'd4096, 1'b0});
    send_req(mk_req(1'b0, 32'h5A5A_1234, 32'd0, 30'd16, 64'h1000));
    send_req(mk_req(1'b1, 32'h5A5A_1234, 32'd0, 30'd16, 64'h1001));
    send_req(mk_req(1'b1, 32'h5A5A_1234, 32'hF000_0000, 30'd2162655, 64'hFFFF_F000));
    send_req(mk_req(1'b1, 32'h5A5A_1234, 32'd0, 30'd2162656, 64'h3000));
    send_req(mk_req(1'b1, 32'h5A5A_1234, 32'd0, 30'h3FFF_FFFF, 64'h3000));

    wait_idle();
    program_media('{32'd0, 1'b0, 13'd4096, 32'hFFFF_FFFF, 13'd1, 1'b0});
    send_req(mk_req(1'b0, 32'd0, 32'h0010_0000, 30'd12288, 64'h1235));
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd268431360, 64'h10));

    wait_idle();
    program_media('{32'd0, 1'b0, 13'd0, 32'hFFFF_FFFF, 13'd3, 1'b1});
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd512, 64'h1000));
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd0, 64'h1000));

    wait_idle();
    program_media('{32'd0, 1'b0, 13'd4097, 32'hFFFF_FFFF, 13'd0, 1'b1});
    send_req(mk_req(1'b1, 32'd0, 32'd0, 30'd4097, 64'h1000));

    wait_idle();
    program_media('{32'hA5, 1'b0, 13'd520, 32'd1000, 13'd6, 1'b0});
    send_req(mk_req(1'b1, 32'hA5, 32'd996, 30'd2080, 64'h10));
    send_req(mk_req(1'b0, 32'hA5, 32'd997, 30'd2080, 64'h14));
    send_req(mk_req(1'b1, 32'hA5, 32'd998, 30'd2080, 64'h10));
    send_req(mk_req(1'b0, 32'hA5, 32'd0, 30'd1000, 64'h10));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p >= RANDOM_PHASES - 2) idle_en = 1'b0;
      wait_idle();
      program_media(random_media());
      repeat (PHASE_ITEMS) send_req(make_request($urandom_range(0, 4) != 0));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d media settings,",
             requests_sent, results, settings_used);
    $display("with random gaps and back-pressure, then a stretch at full rate.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> block_request_splitter.f
src/brs_pkg.sv
src/brs_queue.sv
src/brs_front.sv
src/brs_back.sv
src/block_request_splitter.sv
tb/brs_checker.sv
tb/tb_top.sv
